// ===== hw/rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, register indexes and reset values of the sprite projection.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int POS_W  = 24;
	localparam int DIR_W  = 18;
	localparam int SCR_W  = 13;
	localparam int IDX_W  = 4;
	localparam int CFG_W  = 24;
	localparam int QW     = 31;
	localparam int COL_W  = 16;
	localparam int SIZE_W = 15;
	localparam int DEPTH_W = 26;

	localparam logic [IDX_W-1:0] REG_PLAYER_X    = 4'd0;
	localparam logic [IDX_W-1:0] REG_PLAYER_Y    = 4'd1;
	localparam logic [IDX_W-1:0] REG_VIEW_DIR_X  = 4'd2;
	localparam logic [IDX_W-1:0] REG_VIEW_DIR_Y  = 4'd3;
	localparam logic [IDX_W-1:0] REG_CAM_PLANE_X = 4'd4;
	localparam logic [IDX_W-1:0] REG_CAM_PLANE_Y = 4'd5;
	localparam logic [IDX_W-1:0] REG_SCREEN_W    = 4'd6;
	localparam logic [IDX_W-1:0] REG_SCREEN_H    = 4'd7;

	localparam logic signed [DIR_W-1:0] RST_VIEW_DIR_X  = 18'sd65536;
	localparam logic signed [DIR_W-1:0] RST_CAM_PLANE_Y = 18'sd43254;
	localparam logic [SCR_W-1:0] RST_SCREEN_W = 13'd640;
	localparam logic [SCR_W-1:0] RST_SCREEN_H = 13'd480;

	localparam int H_DIVISOR_DEF = 1;
	localparam int V_DIVISOR_DEF = 1;
	localparam int V_SHIFT_DEF   = 0;

	localparam logic signed [33:0] LIM30     = 34'sd1073741824;
	localparam logic signed [33:0] DEPTH_MAX = 34'sd33554431;
	localparam logic signed [33:0] DEPTH_MIN = -34'sd33554432;
	localparam logic signed [33:0] COL_MAX   = 34'sd32767;
	localparam logic signed [33:0] COL_MIN   = -34'sd32768;

endpackage

// ===== hw/rtl/sprite_screen_projection.sv =====
// ----------------------------------------------------------------------------
// sprite_screen_projection
// Projects one sprite world position to screen size, bounds and depth.
// ----------------------------------------------------------------------------
// The sprite channel (sprite_valid/sprite_ready) takes one world position
// per transaction; the result channel (result_valid/result_ready) returns
// one projection per sprite, in order. The camera pose and the screen size
// are written on the cfg channel, which is always ready; the sprite channel
// is held off in any cycle with a pending cfg write.
// Six stages form the offsets, camera products and numerators, 31 stages of
// restoring division produce one quotient bit each, and three stages
// saturate, add the bounds and clamp them into the output register. A new
// sprite can be taken in every cycle in which no result waits and no cfg
// write is pending. When the receiver stalls, the whole pipeline holds and
// nothing is lost or repeated; sprite_ready stays low as long as a result
// waits, and bubbles in flight are not squeezed out.
// Reset empties the pipeline and loads the default camera pose (facing x,
// plane 0.66) and a 640 by 480 screen.
// ----------------------------------------------------------------------------
module sprite_screen_projection #(
	parameter int H_DIVISOR = ssp_pkg::H_DIVISOR_DEF,
	parameter int V_DIVISOR = ssp_pkg::V_DIVISOR_DEF,
	parameter int V_SHIFT   = ssp_pkg::V_SHIFT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssp_pkg::IDX_W-1:0]          cfg_index,
	input  logic [ssp_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               sprite_valid,
	output logic                               sprite_ready,
	input  logic [ssp_pkg::POS_W-1:0]          sprite_x,
	input  logic [ssp_pkg::POS_W-1:0]          sprite_y,
	input  logic                               last_sprite,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [ssp_pkg::COL_W-1:0]   center_column,
	output logic [ssp_pkg::SIZE_W-1:0]         sprite_height,
	output logic [ssp_pkg::SIZE_W-1:0]         sprite_width,
	output logic [ssp_pkg::SIZE_W-1:0]         top_row,
	output logic signed [ssp_pkg::COL_W-1:0]   bottom_row,
	output logic [ssp_pkg::SIZE_W-1:0]         left_column,
	output logic signed [ssp_pkg::COL_W-1:0]   right_column,
	output logic signed [ssp_pkg::DEPTH_W-1:0] depth,
	output logic                               visible,
	output logic                               last
);

	import ssp_pkg::*;

	localparam int DXW  = POS_W + 1;
	localparam int PRW  = DIR_W + DXW;
	localparam int NUMW = PRW + 1;
	localparam int SUMW = NUMW + 1;
	localparam int HLFW = SCR_W - 1;
	localparam int NCW  = NUMW + HLFW + 1;
	localparam int DETW = 2 * DIR_W + 1;
	localparam int VSW  = 12;
	localparam int NVW  = VSW + DETW;
	localparam int NHW  = SCR_W + 1 + DETW;
	localparam int NDW  = NUMW + 16;
	localparam int VDW  = $clog2(V_DIVISOR + 1);
	localparam int HDW  = $clog2(H_DIVISOR + 1);
	localparam int DVW  = NUMW + VDW;
	localparam int DHW  = NUMW + HDW;
	localparam logic signed [VSW-1:0] VSH = VSW'(V_SHIFT);
	localparam logic [QW-1:0] LIM_H = QW'(LIM30 / V_DIVISOR);
	localparam logic [QW-1:0] LIM_W = QW'(LIM30 / H_DIVISOR);

	logic [POS_W-1:0]        player_x_q, player_y_q;
	logic signed [DIR_W-1:0] view_dir_x_q, view_dir_y_q, cam_plane_x_q, cam_plane_y_q;
	logic [SCR_W-1:0]        screen_w_q, screen_h_q;

	logic signed [DETW-1:0]  det_q;
	logic [DETW-1:0]         det_abs_q;
	logic                    det_zero_q, det_neg_q;
	logic signed [NVW-1:0]   vdet_q;
	logic signed [NHW-1:0]   hdet_q;
	logic [NVW-1:0]          vdet_abs_q;
	logic [NHW-1:0]          hdet_abs_q;
	logic                    vdet_neg_q, vdet_nz_q, hdet_nz_q;
	logic [HLFW-1:0]         half_w_q, half_h_q;

	logic en, take;

	assign cfg_ready    = 1'b1;
	assign en           = !result_valid || result_ready;
	assign sprite_ready = en && !cfg_valid;
	assign take         = sprite_valid && sprite_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q    <= '0;
			player_y_q    <= '0;
			view_dir_x_q  <= RST_VIEW_DIR_X;
			view_dir_y_q  <= '0;
			cam_plane_x_q <= '0;
			cam_plane_y_q <= RST_CAM_PLANE_Y;
			screen_w_q    <= RST_SCREEN_W;
			screen_h_q    <= RST_SCREEN_H;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PLAYER_X:    player_x_q    <= cfg_data[POS_W-1:0];
				REG_PLAYER_Y:    player_y_q    <= cfg_data[POS_W-1:0];
				REG_VIEW_DIR_X:  view_dir_x_q  <= $signed(cfg_data[DIR_W-1:0]);
				REG_VIEW_DIR_Y:  view_dir_y_q  <= $signed(cfg_data[DIR_W-1:0]);
				REG_CAM_PLANE_X: cam_plane_x_q <= $signed(cfg_data[DIR_W-1:0]);
				REG_CAM_PLANE_Y: cam_plane_y_q <= $signed(cfg_data[DIR_W-1:0]);
				REG_SCREEN_W:    screen_w_q    <= cfg_data[SCR_W-1:0];
				REG_SCREEN_H:    screen_h_q    <= cfg_data[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	// Terms that depend on configuration alone are registered here, outside the sprite pipeline.
	always_ff @(posedge clk) begin
		det_q      <= DETW'(cam_plane_x_q * view_dir_y_q) - DETW'(view_dir_x_q * cam_plane_y_q);
		half_w_q   <= screen_w_q[SCR_W-1:1];
		half_h_q   <= screen_h_q[SCR_W-1:1];
		det_abs_q  <= det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
		det_zero_q <= det_q == '0;
		det_neg_q  <= det_q[DETW-1];
		vdet_q     <= NVW'(VSH) * NVW'(det_q);
		hdet_q     <= NHW'($signed({1'b0, screen_h_q})) * NHW'(det_q);
		vdet_abs_q <= vdet_q[NVW-1] ? NVW'(-vdet_q) : NVW'(vdet_q);
		vdet_neg_q <= vdet_q[NVW-1];
		vdet_nz_q  <= vdet_q != '0;
		hdet_abs_q <= hdet_q[NHW-1] ? NHW'(-hdet_q) : NHW'(hdet_q);
		hdet_nz_q  <= hdet_q != '0;
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6;
	logic signed [DXW-1:0]  dx_s1, dy_s1;
	logic signed [PRW-1:0]  pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [NUMW-1:0] nx_s3, ny_s3, ny_s4;
	logic signed [SUMW-1:0] sum_s4;
	logic signed [NCW-1:0]  nc_s5;
	logic [NUMW-1:0]        ny_abs_s5, ny_abs_s6;
	logic                   ny_neg_s5, ny_nz_s5, ny_neg_s6, ny_nz_s6;
	logic [NCW-1:0]         nc_abs_s6;
	logic                   nc_neg_s6, nc_nz_s6;
	logic [DVW-1:0]         dh_s6;
	logic [DHW-1:0]         dw_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1     <= $signed({1'b0, sprite_x}) - $signed({1'b0, player_x_q});
			dy_s1     <= $signed({1'b0, sprite_y}) - $signed({1'b0, player_y_q});
			l_s1      <= last_sprite;
			pa_s2     <= PRW'(view_dir_y_q) * PRW'(dx_s1);
			pb_s2     <= PRW'(view_dir_x_q) * PRW'(dy_s1);
			pc_s2     <= PRW'(cam_plane_y_q) * PRW'(dx_s1);
			pd_s2     <= PRW'(cam_plane_x_q) * PRW'(dy_s1);
			l_s2      <= l_s1;
			nx_s3     <= NUMW'(pa_s2) - NUMW'(pb_s2);
			ny_s3     <= NUMW'(pd_s2) - NUMW'(pc_s2);
			l_s3      <= l_s2;
			sum_s4    <= SUMW'(nx_s3) + SUMW'(ny_s3);
			ny_s4     <= ny_s3;
			l_s4      <= l_s3;
			nc_s5     <= NCW'($signed({1'b0, half_w_q})) * NCW'(sum_s4);
			ny_abs_s5 <= ny_s4[NUMW-1] ? NUMW'(-ny_s4) : NUMW'(ny_s4);
			ny_neg_s5 <= ny_s4[NUMW-1];
			ny_nz_s5  <= ny_s4 != '0;
			l_s5      <= l_s4;
			nc_abs_s6 <= nc_s5[NCW-1] ? NCW'(-nc_s5) : NCW'(nc_s5);
			nc_neg_s6 <= nc_s5[NCW-1];
			nc_nz_s6  <= nc_s5 != '0;
			ny_abs_s6 <= ny_abs_s5;
			ny_neg_s6 <= ny_neg_s5;
			ny_nz_s6  <= ny_nz_s5;
			dh_s6     <= DVW'(ny_abs_s5) * DVW'(V_DIVISOR);
			dw_s6     <= DHW'(ny_abs_s5) * DHW'(H_DIVISOR);
			l_s6      <= l_s5;
		end
	end

	logic ovf_d, ovf_c, ovf_v, ovf_h;
	assign ovf_d = DETW'(ny_abs_s6[NUMW-1:QW-16]) >= det_abs_q;
	assign ovf_c = NUMW'(nc_abs_s6[NCW-1:QW]) >= ny_abs_s6;
	assign ovf_v = NUMW'(vdet_abs_q[NVW-1:QW]) >= ny_abs_s6;
	assign ovf_h = NUMW'(hdet_abs_q[NHW-1:QW]) >= ny_abs_s6;

	logic [QW-1:0] qd, qc, qv, qh, qw;
	logic [5:0] td;
	logic [4:0] tc, tv;
	logic [2:0] th, tw;
	logic vd, vc, vv, vh, vw;

	ssp_div #(.NW(NDW), .DW(DETW), .QW(QW), .TW(6)) u_div_depth (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.n({ny_abs_s6, 16'b0}), .d(det_abs_q),
		.tag_in({l_s6, det_zero_q, ny_nz_s6 && !ny_neg_s6, ny_neg_s6,
			ny_neg_s6 ^ det_neg_q, ovf_d}),
		.out_valid(vd), .q(qd), .tag_out(td)
	);

	ssp_div #(.NW(NCW), .DW(NUMW), .QW(QW), .TW(5)) u_div_center (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.n(nc_abs_s6), .d(ny_abs_s6),
		.tag_in({!ny_nz_s6, nc_nz_s6 && !nc_neg_s6, nc_neg_s6,
			nc_neg_s6 ^ ny_neg_s6, ovf_c}),
		.out_valid(vc), .q(qc), .tag_out(tc)
	);

	ssp_div #(.NW(NVW), .DW(NUMW), .QW(QW), .TW(5)) u_div_vmove (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.n(vdet_abs_q), .d(ny_abs_s6),
		.tag_in({!ny_nz_s6, vdet_nz_q && !vdet_neg_q, vdet_neg_q,
			vdet_neg_q ^ ny_neg_s6, ovf_v}),
		.out_valid(vv), .q(qv), .tag_out(tv)
	);

	ssp_div #(.NW(NHW), .DW(DVW), .QW(QW), .TW(3)) u_div_height (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.n(hdet_abs_q), .d(dh_s6), .tag_in({!ny_nz_s6, hdet_nz_q, ovf_h}),
		.out_valid(vh), .q(qh), .tag_out(th)
	);

	ssp_div #(.NW(NHW), .DW(DHW), .QW(QW), .TW(3)) u_div_width (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.n(hdet_abs_q), .d(dw_s6), .tag_in({!ny_nz_s6, hdet_nz_q, ovf_h}),
		.out_valid(vw), .q(qw), .tag_out(tw)
	);

	function automatic logic signed [33:0] sat_q(
		input logic [QW-1:0]     q,
		input logic [4:0]        t,
		input logic signed [33:0] lo,
		input logic signed [33:0] hi
	);
		logic signed [33:0] v;
		v = t[1] ? -$signed({3'b0, q}) : $signed({3'b0, q});
		priority if (t[4]) return t[3] ? hi : (t[2] ? lo : '0);
		else if (t[0])     return t[1] ? lo : hi;
		else if (v < lo)   return lo;
		else if (v > hi)   return hi;
		else               return v;
	endfunction

	function automatic logic [QW-1:0] sat_mag(
		input logic [QW-1:0] q,
		input logic [2:0]    t,
		input logic [QW-1:0] lim
	);
		priority if (t[2]) return t[1] ? lim : '0;
		else if (t[0])     return lim;
		else if (q > lim)  return lim;
		else               return q;
	endfunction

	function automatic logic signed [33:0] clamp(
		input logic signed [33:0] v,
		input logic signed [33:0] lo,
		input logic signed [33:0] hi
	);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	logic v_s7, v_s8, l_s7, l_s8, vis_s7, vis_s8;
	logic signed [DEPTH_W-1:0] depth_s7, depth_s8;
	logic signed [33:0] center_s7, vmove_s7, center_s8, top_s8, bot_s8, left_s8, right_s8;
	logic [QW-1:0] h_s7, w_s7, h_s8, w_s8;
	logic signed [33:0] depth_sat;

	assign depth_sat = sat_q(qd, td[4:0], DEPTH_MIN, DEPTH_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7         <= 1'b0;
			v_s8         <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s7         <= vd && vc && vv && vh && vw;
			v_s8         <= v_s7;
			result_valid <= v_s8;
		end
	end

	logic signed [33:0] hh_e, hs_e, ws_e, bot_c, right_c;
	assign hh_e = 34'(half_h_q);
	assign hs_e = 34'(screen_h_q);
	assign ws_e = 34'(screen_w_q);
	assign bot_c   = (bot_s8 >= hs_e) ? hs_e - 34'sd1 : bot_s8;
	assign right_c = (right_s8 >= ws_e) ? ws_e - 34'sd1 : right_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			depth_s7      <= DEPTH_W'(depth_sat);
			vis_s7        <= (depth_sat > 34'sd0) && !td[4];
			l_s7          <= td[5];
			center_s7     <= sat_q(qc, tc, -LIM30, LIM30);
			vmove_s7      <= sat_q(qv, tv, -LIM30, LIM30);
			h_s7          <= sat_mag(qh, th, LIM_H);
			w_s7          <= sat_mag(qw, tw, LIM_W);

			depth_s8      <= depth_s7;
			vis_s8        <= vis_s7;
			l_s8          <= l_s7;
			center_s8     <= center_s7;
			h_s8          <= h_s7;
			w_s8          <= w_s7;
			top_s8        <= hh_e - 34'(h_s7 >> 1) + vmove_s7;
			bot_s8        <= hh_e + 34'(h_s7 >> 1) + vmove_s7;
			left_s8       <= center_s7 - 34'(w_s7 >> 1);
			right_s8      <= center_s7 + 34'(w_s7 >> 1);

			center_column <= COL_W'(clamp(center_s8, COL_MIN, COL_MAX));
			sprite_height <= SIZE_W'(clamp(34'(h_s8), '0, COL_MAX));
			sprite_width  <= SIZE_W'(clamp(34'(w_s8), '0, COL_MAX));
			top_row       <= SIZE_W'(clamp(top_s8, '0, COL_MAX));
			bottom_row    <= COL_W'(clamp(bot_c, COL_MIN, COL_MAX));
			left_column   <= SIZE_W'(clamp(left_s8, '0, COL_MAX));
			right_column  <= COL_W'(clamp(right_c, COL_MIN, COL_MAX));
			depth         <= depth_s8;
			visible       <= vis_s8;
			last          <= l_s8;
		end
	end

endmodule

// ===== hw/rtl/ssp_div.sv =====
// ----------------------------------------------------------------------------
// ssp_div
// Pipelined restoring divider of unsigned values, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssp_div #(
	parameter int NW = 60,
	parameter int DW = 37,
	parameter int QW = 31,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [QW-1:0] q,
	output logic [TW-1:0] tag_out
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_q [QW];
	logic [DW-1:0] dv_q  [QW];
	logic [QW-1:0] quo_q [QW];
	logic [TW-1:0] tag_q [QW];
	logic          vld_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] rem_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [TW-1:0] t_in;
		logic          v_in;
		logic [RW-1:0] sub;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = RW'(n);
			assign d_in   = d;
			assign q_in   = '0;
			assign t_in   = tag_in;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign d_in   = dv_q[k-1];
			assign q_in   = quo_q[k-1];
			assign t_in   = tag_q[k-1];
			assign v_in   = vld_q[k-1];
		end

		assign sub  = RW'(d_in) << (QW - 1 - k);
		assign take = rem_in >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? rem_in - sub : rem_in;
				dv_q[k]  <= d_in;
				quo_q[k] <= (q_in << 1) | QW'(take);
				tag_q[k] <= t_in;
			end
		end
	end

	assign out_valid = vld_q[QW-1];
	assign q         = quo_q[QW-1];
	assign tag_out   = tag_q[QW-1];

endmodule

// ===== hw/rtl/ssp_chk.sv =====
// ----------------------------------------------------------------------------
// ssp_chk
// Port-level checks of the sprite projection, bound to the top level.
// ----------------------------------------------------------------------------
module ssp_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_valid,
	input logic                               sprite_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [ssp_pkg::COL_W-1:0]   center_column,
	input logic signed [ssp_pkg::DEPTH_W-1:0] depth,
	input logic                               visible
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(depth)
			&& $stable(center_column))
		else $error("result changed while stalled");

	a_vis: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && visible |-> depth > 0)
		else $error("visible sprite without positive depth");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !cfg_valid |-> sprite_ready)
		else $error("sprite channel blocked with empty output");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> !sprite_ready)
		else $error("sprite transaction taken during a cfg write");

	a_rst: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid after reset");

endmodule

bind sprite_screen_projection ssp_chk u_ssp_chk (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite projection testbench
// Drives sprite positions through several camera poses and screen sizes and
// checks each result against a cycle-free model, or typed rows' fixed values.
// ----------------------------------------------------------------------------
module tb;
	import ssp_pkg::*;

	localparam int    RUN_LIMIT = 600000;
	localparam int    PIPE_WAIT = 60;
	localparam longint SAT30    = 64'sd1073741824;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 4'd8;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 4'd15;

	typedef struct packed {
		logic signed [COL_W-1:0]   center;
		logic [SIZE_W-1:0]         height;
		logic [SIZE_W-1:0]         width;
		logic [SIZE_W-1:0]         top;
		logic signed [COL_W-1:0]   bottom;
		logic [SIZE_W-1:0]         left;
		logic signed [COL_W-1:0]   right;
		logic signed [DEPTH_W-1:0] depth;
		logic                      vis;
		logic                      fin;
	} projection_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             fin;
		logic             typed;
		projection_t      exp;
	} sprite_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic sprite_valid = 1'b0;
	logic sprite_ready;
	logic [POS_W-1:0] sprite_x = '0;
	logic [POS_W-1:0] sprite_y = '0;
	logic last_sprite = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [COL_W-1:0] center_column;
	logic [SIZE_W-1:0] sprite_height, sprite_width, top_row, left_column;
	logic signed [COL_W-1:0] bottom_row, right_column;
	logic signed [DEPTH_W-1:0] depth;
	logic visible, last;

	sprite_screen_projection dut (.*);

	always #2 clk = ~clk;

	longint ply_x, ply_y, dir_x, dir_y, pln_x, pln_y, scr_w, scr_h;
	projection_t pending_proj[$];
	int fail_count = 0;
	int checked = 0;
	int sent = 0;
	int cycles = 0;
	int stall_mode = 0;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint div_sat(longint n, longint d, longint lo, longint hi);
		if (d == 0)
			return n > 0 ? hi : (n < 0 ? lo : 0);
		return clamp(n / d, lo, hi);
	endfunction

	function automatic projection_t project_sprite(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
			logic fin);
		longint dx, dy, det, nx, ny, half, dep, ctr, vm, q, h, w, top, bot, lft, rgt;
		projection_t p;
		dx = longint'(sx) - ply_x;
		dy = longint'(sy) - ply_y;
		det = pln_x * dir_y - dir_x * pln_y;
		nx = dir_y * dx - dir_x * dy;
		ny = -pln_y * dx + pln_x * dy;
		half = scr_w / 2;
		dep = div_sat(ny * 65536, det, -33554432, 33554431);
		ctr = div_sat(half * (ny + nx), ny, -SAT30, SAT30);
		vm = div_sat(longint'(V_SHIFT_DEF) * det, ny, -SAT30, SAT30);
		q = div_sat(scr_h * det, ny, -SAT30, SAT30);
		if (q < 0)
			q = -q;
		h = (V_DIVISOR_DEF >= 1) ? q / V_DIVISOR_DEF : 32767;
		w = (H_DIVISOR_DEF >= 1) ? q / H_DIVISOR_DEF : 32767;
		top = -h / 2 + scr_h / 2 + vm;
		if (top < 0)
			top = 0;
		bot = h / 2 + scr_h / 2 + vm;
		if (bot >= scr_h)
			bot = scr_h - 1;
		lft = -w / 2 + ctr;
		if (lft < 0)
			lft = 0;
		rgt = w / 2 + ctr;
		if (rgt >= scr_w)
			rgt = scr_w - 1;
		p.center = COL_W'(clamp(ctr, -32768, 32767));
		p.height = SIZE_W'(clamp(h, 0, 32767));
		p.width = SIZE_W'(clamp(w, 0, 32767));
		p.top = SIZE_W'(clamp(top, 0, 32767));
		p.bottom = COL_W'(clamp(bot, -32768, 32767));
		p.left = SIZE_W'(clamp(lft, 0, 32767));
		p.right = COL_W'(clamp(rgt, -32768, 32767));
		p.depth = DEPTH_W'(dep);
		p.vis = (dep > 0 && det != 0);
		p.fin = fin;
		return p;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		projection_t e;
		cycles <= cycles + 1;
		if (cycles % 256 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= ($urandom_range(0, 3) != 0);
			default: result_ready <= ((cycles % 11) > 3);
		endcase
		if (result_valid && result_ready) begin
			if (pending_proj.size() == 0) begin
				$error("result with no sprite outstanding");
				fail_count++;
			end else begin
				e = pending_proj.pop_front();
				checked++;
				check_field("center_column", e.center, center_column);
				check_field("sprite_height", e.height, sprite_height);
				check_field("sprite_width", e.width, sprite_width);
				check_field("top_row", e.top, top_row);
				check_field("bottom_row", e.bottom, bottom_row);
				check_field("left_column", e.left, left_column);
				check_field("right_column", e.right, right_column);
				check_field("depth", e.depth, depth);
				check_field("visible", e.vis, visible);
				check_field("last", e.fin, last);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_proj.size() != 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PLAYER_X: ply_x = longint'(data[POS_W-1:0]);
			REG_PLAYER_Y: ply_y = longint'(data[POS_W-1:0]);
			REG_VIEW_DIR_X: dir_x = longint'($signed(data[DIR_W-1:0]));
			REG_VIEW_DIR_Y: dir_y = longint'($signed(data[DIR_W-1:0]));
			REG_CAM_PLANE_X: pln_x = longint'($signed(data[DIR_W-1:0]));
			REG_CAM_PLANE_Y: pln_y = longint'($signed(data[DIR_W-1:0]));
			REG_SCREEN_W: scr_w = longint'(data[SCR_W-1:0]);
			REG_SCREEN_H: scr_h = longint'(data[SCR_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic configure(longint px, longint py, longint vx, longint vy, longint cx,
			longint cy, longint w, longint h);
		wait_idle();
		write_reg(REG_PLAYER_X, CFG_W'(px));
		write_reg(REG_PLAYER_Y, CFG_W'(py));
		write_reg(REG_VIEW_DIR_X, CFG_W'(vx));
		write_reg(REG_VIEW_DIR_Y, CFG_W'(vy));
		write_reg(REG_CAM_PLANE_X, CFG_W'(cx));
		write_reg(REG_CAM_PLANE_Y, CFG_W'(cy));
		write_reg(REG_SCREEN_W, CFG_W'(w));
		write_reg(REG_SCREEN_H, CFG_W'(h));
	endtask

	task automatic send_sprite(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic fin,
			logic typed, projection_t t);
		sprite_valid <= 1'b1;
		sprite_x <= x;
		sprite_y <= y;
		last_sprite <= fin;
		do @(posedge clk); while (!sprite_ready);
		pending_proj.push_back(typed ? t : project_sprite(x, y, fin));
		sent++;
	endtask

	function automatic logic [POS_W-1:0] pick_coord(longint base);
		int sel;
		longint v;
		sel = $urandom_range(0, 5);
		case (sel)
			0, 1: v = $urandom_range(0, 24'hFFFFFF);
			2, 3: v = base + $signed($urandom_range(0, 20'hFFFFF)) - 20'h80000;
			4: v = base + $signed($urandom_range(0, 8191)) - 4096;
			default: v = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
		endcase
		return POS_W'(clamp(v, 0, 24'hFFFFFF));
	endfunction

	task automatic random_sprites(int n);
		int burst;
		burst = $urandom_range(1, 40);
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				sprite_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst = $urandom_range(1, 40);
			end
			send_sprite(pick_coord(ply_x), pick_coord(ply_y), ($urandom_range(0, 7) == 0),
				1'b0, '0);
			burst--;
		end
		sprite_valid <= 1'b0;
	endtask

	task automatic random_pose();
		longint w, h;
		w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4096);
		h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4096);
		configure($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			longint'($urandom_range(0, 262143)) - 131072,
			longint'($urandom_range(0, 262143)) - 131072,
			longint'($urandom_range(0, 262143)) - 131072,
			longint'($urandom_range(0, 262143)) - 131072, w, h);
	endtask

	sprite_row_t dir_rows [10] = '{
		'{24'h000000, 24'h000000, 1'b0, 1'b1,
			'{16'sd0, 15'd32767, 15'd32767, 15'd0, 16'sd479, 15'd0, 16'sd639,
			26'sd0, 1'b0, 1'b0}},
		'{24'h010000, 24'h000000, 1'b1, 1'b1,
			'{16'sd320, 15'd480, 15'd480, 15'd0, 16'sd479, 15'd80, 16'sd560,
			26'sd65536, 1'b1, 1'b1}},
		'{24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, '0},
		'{24'h000000, 24'hFFFFFF, 1'b0, 1'b0, '0},
		'{24'hFFFFFF, 24'h000000, 1'b0, 1'b0, '0},
		'{24'h010000, 24'h010000, 1'b0, 1'b0, '0},
		'{24'h000001, 24'h000001, 1'b1, 1'b0, '0},
		'{24'h000000, 24'h008000, 1'b0, 1'b0, '0},
		'{24'h040000, 24'hFF0000, 1'b0, 1'b0, '0},
		'{24'hAAAAAA, 24'h555555, 1'b1, 1'b0, '0}
	};

	initial begin
		ply_x = 0;
		ply_y = 0;
		dir_x = RST_VIEW_DIR_X;
		dir_y = 0;
		pln_x = 0;
		pln_y = RST_CAM_PLANE_Y;
		scr_w = RST_SCREEN_W;
		scr_h = RST_SCREEN_H;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i])
			send_sprite(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i].exp);
		sprite_valid <= 1'b0;

		configure(24'hFFFFFF, 0, -131072, 131071, 131071, -131072, 4096, 4096);
		random_sprites(30);
		configure(24'h080000, 24'h080000, 0, 0, 0, 0, 1, 1);
		random_sprites(30);
		configure(24'h080000, 24'h040000, 0, 65536, -43254, 0, 0, 0);
		random_sprites(30);
		configure(0, 24'hFFFFFF, 131071, 131071, 131071, 131071, 640, 480);
		random_sprites(30);
		wait_idle();
		write_reg(REG_SPARE_LO, CFG_W'($urandom));
		write_reg(REG_SPARE_HI, CFG_W'($urandom));
		random_sprites(30);
		for (int ph = 0; ph < 10; ph++) begin
			random_pose();
			random_sprites(165);
		end

		while (pending_proj.size() != 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
		$display("Projected %0d sprites over 15 camera and screen settings; %0d results checked.",
			sent, checked);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_div.sv
hw/rtl/sprite_screen_projection.sv
hw/rtl/ssp_chk.sv
dv/tb.sv
